@@ hdl/d2f48_pkg.sv @@
package d2f48_pkg;
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_UNF   = 2'd2;
    localparam logic [1:0] ST_INVAL = 2'd3;

    localparam int unsigned EXP_W = 13;
    localparam logic [63:0] FRAC_KEEP_MASK = 64'h7FFF_FFFF_FF00_0000;
    localparam logic [63:0] ROUND_ADD = 64'h0000_0000_0100_0000;
    localparam logic [63:0] ROUND_BIT = 64'h0000_0000_0080_0000;
    localparam logic signed [EXP_W-1:0] EXP_MAX = 13'sd127;
    localparam logic signed [EXP_W-1:0] EXP_MIN = -13'sd128;

    // stage 1 -> stage 2: magnitude split, subnormal leading-one position
    typedef struct packed {
        logic                    neg;
        logic                    nonzero;
        logic                    inval;
        logic [51:0]             frac;
        logic                    subn;
        logic [5:0]              p;
        logic signed [EXP_W-1:0] ex;
    } split_t;

    // stage 2 -> stage 3: signed, normalized mantissa
    typedef struct packed {
        logic                    nonzero;
        logic                    inval;
        logic [63:0]             m;
        logic signed [EXP_W-1:0] ex;
    } norm_t;
endpackage

@@ hdl/d2f48_split.sv @@
module d2f48_split (
    input  logic [63:0]           double_bits,
    output d2f48_pkg::split_t     split
);
    import d2f48_pkg::*;

    logic [10:0] efield;
    logic [5:0]  p;
    assign efield = double_bits[62:52];

    // leading-one position of a subnormal fraction
    always_comb
    begin
        p = 6'd0;
        for (int i = 1; i < 52; i++)
        begin
            if (double_bits[i])
            begin
                p = 6'(i);
            end
        end
    end

    always_comb
    begin
        split.neg     = double_bits[63];
        split.inval   = (efield == 11'h7FF);
        split.frac    = double_bits[51:0];
        split.subn    = (efield == 11'd0);
        split.nonzero = (efield != 11'd0) || (double_bits[51:0] != 52'd0);
        split.p       = p;
        split.ex      = $signed({2'b00, efield}) - 13'sd1022;
    end
endmodule

@@ hdl/d2f48_norm.sv @@
module d2f48_norm (
    input  d2f48_pkg::split_t split,
    output d2f48_pkg::norm_t  norm
);
    import d2f48_pkg::*;

    logic [63:0] mag;
    logic [63:0] m;
    logic signed [EXP_W-1:0] ex;

    always_comb
    begin
        if (!split.nonzero)
        begin
            mag = 64'd0;
            ex  = '0;
        end
        else if (!split.subn)
        begin
            mag = {2'b01, split.frac, 10'd0};
            ex  = split.ex;
        end
        else
        begin
            mag = {12'd0, split.frac} << (6'd62 - split.p);
            ex  = $signed({7'd0, split.p}) - 13'sd1073;
        end
        m = split.neg ? (64'd0 - mag) : mag;
        if (m != 64'd0 && m[63] == m[62])
        begin
            m  = m << 1;
            ex = ex - 13'sd1;
        end
        norm.nonzero = split.nonzero;
        norm.inval   = split.inval;
        norm.m       = m;
        norm.ex      = ex;
    end
endmodule

@@ hdl/d2f48_round.sv @@
module d2f48_round (
    input  d2f48_pkg::norm_t norm,
    output logic [15:0]      word_high,
    output logic [15:0]      word_mid,
    output logic [15:0]      word_low,
    output logic [1:0]       status
);
    import d2f48_pkg::*;

    logic [63:0] m;
    logic signed [EXP_W-1:0] ex;

    always_comb
    begin
        m  = norm.m;
        ex = norm.ex;
        if ((m & ROUND_BIT) != 64'd0)
        begin
            if ((m & FRAC_KEEP_MASK) == FRAC_KEEP_MASK)
            begin
                m  = {m[63], m[63:1]} + ROUND_BIT;
                ex = ex + 13'sd1;
            end
            else
            begin
                m = m + ROUND_ADD;
            end
        end
        word_high = 16'd0;
        word_mid  = 16'd0;
        word_low  = 16'd0;
        if (norm.inval)
            status = ST_INVAL;
        else if (ex > EXP_MAX)
            status = ST_OVF;
        else if (norm.nonzero && ex < EXP_MIN)
            status = ST_UNF;
        else
        begin
            status    = ST_OK;
            word_high = m[63:48];
            word_mid  = m[47:32];
            word_low  = {m[31:24], ex[7:0]};
        end
    end
endmodule

@@ hdl/double_to_48bit_float_convert.sv @@
// channel | dir | valid    | ready    | payload
// in      | in  | in_valid | in_ready | double_bits[63:0]
// out     | out | out_valid| out_ready| word_high, word_mid, word_low, status
//
// Three register stages: split/leading-one, shift/negate, round/pack.
// One beat per cycle sustained while out_ready is held high.
// rst_n (async, low) clears the stage valid bits only.
// A stage advances when it is empty or the stage after it moves; a stall at
// out_ready backs up through every stage without dropping a beat.
module double_to_48bit_float_convert (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] double_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] word_high,
    output logic [15:0] word_mid,
    output logic [15:0] word_low,
    output logic [1:0]  status
);
    import d2f48_pkg::*;

    split_t split_next, split_reg;
    norm_t  norm_next,  norm_reg;
    logic [15:0] hi_next, mid_next, lo_next;
    logic [1:0]  st_next;
    logic [15:0] hi_reg, mid_reg, lo_reg;
    logic [1:0]  st_reg;
    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    // per-stage enables, back to front
    assign adv3 = !v3_reg || out_ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign in_ready = adv1;

    d2f48_split u_split (.double_bits(double_bits), .split(split_next));
    d2f48_norm  u_norm  (.split(split_reg), .norm(norm_next));
    d2f48_round u_round (
        .norm(norm_reg), .word_high(hi_next), .word_mid(mid_next),
        .word_low(lo_next), .status(st_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1) split_reg <= split_next;
        if (adv2) norm_reg  <= norm_next;
        if (adv3)
        begin
            hi_reg  <= hi_next;
            mid_reg <= mid_next;
            lo_reg  <= lo_next;
            st_reg  <= st_next;
        end
    end

    assign out_valid = v3_reg;
    assign word_high = hi_reg;
    assign word_mid  = mid_reg;
    assign word_low  = lo_reg;
    assign status    = st_reg;
endmodule
